### rtl/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared types and constants of the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int ChanW    = 8;   // input channel width
  localparam int HueW     = 9;   // hue in degrees
  localparam int PctW     = 7;   // percent fields
  localparam int HueNumW  = 17;  // hue numerator, below 360 * 255
  localparam int SatNumW  = 15;  // saturation numerator, d * 100
  localparam int DivQW    = 9;   // quotient bits of both dividers
  localparam int LxW      = 13;  // ten times max plus min

  // Lightness is floor(10 * sum / 51), estimated by a reciprocal multiply
  localparam int LightDiv   = 51;
  localparam int LightRecip = 1285;
  localparam int LightShift = 16;

  // Largest channel, ties resolved red, green, blue
  typedef enum logic [1:0] {
    SEXT_RED,
    SEXT_GREEN,
    SEXT_BLUE
  } sext_e;

  // Operands handed from the front end to the dividers
  typedef struct packed {
    logic [HueNumW-1:0] hue_num;
    logic [ChanW-1:0]   delta;
    logic [SatNumW-1:0] sat_num;
    logic [ChanW-1:0]   sat_den;
    logic [PctW-1:0]    light;
    logic               grey;
  } div_op_t;

endpackage

### rtl/rgbhsl_if.sv
// ----------------------------------------------------------------------------
// rgbhsl_if
// Valid/ready channels for RGB pixels and HSL results.
// ----------------------------------------------------------------------------
interface rgbhsl_rgb_if;
  logic                          valid;
  logic                          ready;
  logic [rgbhsl_pkg::ChanW-1:0]  red;
  logic [rgbhsl_pkg::ChanW-1:0]  green;
  logic [rgbhsl_pkg::ChanW-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbhsl_hsl_if;
  logic                         valid;
  logic                         ready;
  logic [rgbhsl_pkg::HueW-1:0]  hue_degrees;
  logic [rgbhsl_pkg::PctW-1:0]  saturation_percent;
  logic [rgbhsl_pkg::PctW-1:0]  lightness_percent;

  modport source (output valid, hue_degrees, saturation_percent, lightness_percent,
                  input ready);
  modport sink   (input valid, hue_degrees, saturation_percent, lightness_percent,
                  output ready);
endinterface

### rtl/rgbhsl_front.sv
// ----------------------------------------------------------------------------
// rgbhsl_front
// Three-stage front end: max/min and sextant, numerators and divisors,
// lightness correction.
// ----------------------------------------------------------------------------
module rgbhsl_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rgbhsl_pkg::ChanW-1:0]  red_i,
  input  logic [rgbhsl_pkg::ChanW-1:0]  green_i,
  input  logic [rgbhsl_pkg::ChanW-1:0]  blue_i,
  output logic                          valid_o,
  output rgbhsl_pkg::div_op_t           op_o
);

  localparam int CW = rgbhsl_pkg::ChanW;

  // Stage 1: extremes, sextant, signed channel difference
  rgbhsl_pkg::sext_e   sel_d, sel_q;
  logic [CW-1:0]       mx_d, mx_q, mn_d, mn_q;
  logic signed [CW:0]  diff_d, diff_q;
  logic                grey1_q;
  logic                vld1_q;

  always_comb begin
    priority if (red_i >= green_i && red_i >= blue_i) begin
      sel_d  = rgbhsl_pkg::SEXT_RED;
      mx_d   = red_i;
      diff_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sel_d  = rgbhsl_pkg::SEXT_GREEN;
      mx_d   = green_i;
      diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sel_d  = rgbhsl_pkg::SEXT_BLUE;
      mx_d   = blue_i;
      diff_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    mn_d = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn_d) begin
      mn_d = blue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q   <= sel_d;
      mx_q    <= mx_d;
      mn_q    <= mn_d;
      diff_q  <= diff_d;
      grey1_q <= (mx_d == mn_d);
    end
  end

  // Stage 2: hue numerator, saturation operands, lightness estimate
  logic [CW-1:0]                     delta;
  logic [CW:0]                       sum;
  logic [rgbhsl_pkg::HueNumW-1:0]    hoff;
  logic signed [rgbhsl_pkg::HueNumW:0] hsum;
  logic [rgbhsl_pkg::LxW-1:0]        lx;
  logic [rgbhsl_pkg::LxW+10-1:0]     lprod;

  logic [rgbhsl_pkg::HueNumW-1:0]    hnum_q;
  logic [CW-1:0]                     delta_q;
  logic [rgbhsl_pkg::SatNumW-1:0]    snum_q;
  logic [CW-1:0]                     sden_d, sden_q;
  logic [rgbhsl_pkg::LxW-1:0]        lx_q;
  logic [rgbhsl_pkg::PctW-1:0]       lest_q;
  logic                              grey2_q;
  logic                              vld2_q;

  always_comb begin
    delta = mx_q - mn_q;
    sum   = {1'b0, mx_q} + {1'b0, mn_q};
    unique case (sel_q)
      rgbhsl_pkg::SEXT_RED:   hoff = diff_q[CW] ? rgbhsl_pkg::HueNumW'(delta * 9'd360)
                                                : '0;
      rgbhsl_pkg::SEXT_GREEN: hoff = rgbhsl_pkg::HueNumW'(delta * 7'd120);
      rgbhsl_pkg::SEXT_BLUE:  hoff = rgbhsl_pkg::HueNumW'(delta * 8'd240);
      default:                hoff = '0;
    endcase
    hsum = (rgbhsl_pkg::HueNumW+1)'(diff_q) * $signed((rgbhsl_pkg::HueNumW+1)'(60))
         + $signed({1'b0, hoff});
    sden_d = (sum > 9'd255) ? CW'(10'd510 - {1'b0, sum}) : sum[CW-1:0];
    lx     = rgbhsl_pkg::LxW'(sum * 4'd10);
    lprod  = (rgbhsl_pkg::LxW+10)'(lx * 11'(rgbhsl_pkg::LightRecip));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hnum_q  <= hsum[rgbhsl_pkg::HueNumW-1:0];
      delta_q <= delta;
      snum_q  <= rgbhsl_pkg::SatNumW'(delta * 7'd100);
      sden_q  <= sden_d;
      lx_q    <= lx;
      lest_q  <= lprod[rgbhsl_pkg::LightShift +: rgbhsl_pkg::PctW];
      grey2_q <= grey1_q;
    end
  end

  // Stage 3: correct the lightness estimate by at most one
  logic [rgbhsl_pkg::LxW-1:0] lrem;
  rgbhsl_pkg::div_op_t        op_d, op_q;

  always_comb begin
    lrem          = lx_q - rgbhsl_pkg::LxW'(lest_q * 6'(rgbhsl_pkg::LightDiv));
    op_d.hue_num  = hnum_q;
    op_d.delta    = delta_q;
    op_d.sat_num  = snum_q;
    op_d.sat_den  = sden_q;
    op_d.light    = (lrem >= rgbhsl_pkg::LxW'(rgbhsl_pkg::LightDiv)) ? lest_q + 1'b1
                                                                     : lest_q;
    op_d.grey     = grey2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_d;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q  <= 1'b0;
      vld2_q  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld1_q  <= valid_i;
      vld2_q  <= vld1_q;
      valid_o <= vld2_q;
    end
  end

  assign op_o = op_q;

endmodule

### rtl/rgbhsl_div.sv
// ----------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module rgbhsl_div #(
  parameter int NW = 17,  // numerator width
  parameter int DW = 8,   // divisor width
  parameter int QW = 9,   // quotient bits; numerator below divisor * 2**QW
  parameter int TW = 8    // tag width
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [TW-1:0] tag_o
);

  localparam int WW = NW + DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [TW-1:0] tag_q [QW];
  logic [QW-1:0] vld_q;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int Sh = QW - 1 - i;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [WW-1:0] trial;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign tag_in = tag_q[i-1];
      assign vld_in = vld_q[i-1];
    end

    // Try to subtract the shifted divisor
    assign trial = WW'(den_in) << Sh;
    assign take  = WW'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= take ? NW'(WW'(rem_in) - trial) : rem_in;
        den_q[i] <= den_in;
        quo_q[i] <= quo_in | (QW'(take) << Sh);
        tag_q[i] <= tag_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

### rtl/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Converts 8-bit RGB pixels to hue (degrees), saturation and lightness
// (percent), all truncated toward zero.
// ----------------------------------------------------------------------------
// One pixel enters per clock unless the pipeline holds: three
// front-end stages (extremes, operands, lightness correction) feed two
// 9-stage restoring dividers that run side by side, one quotient bit per
// stage. The whole pipeline advances together; it holds while the output
// beat waits and is not taken, so ready follows the output ready and the
// occupancy of the last stage. Grey pixels give zero hue and saturation.
module rgb_to_hsl_converter (
  input  logic                clk_i,
  input  logic                rst_ni,
  rgbhsl_rgb_if.sink          pix_i,
  rgbhsl_hsl_if.source        hsl_o
);

  localparam int CW = rgbhsl_pkg::ChanW;
  localparam int QW = rgbhsl_pkg::DivQW;
  localparam int PW = rgbhsl_pkg::PctW;

  logic                 en;
  logic                 fe_vld;
  rgbhsl_pkg::div_op_t  fe_op;
  logic                 hdiv_vld, sdiv_vld;
  logic [QW-1:0]        hue_quot, sat_quot;
  logic [PW:0]          htag;
  logic                 sgrey;

  // Advance the pipeline unless the output beat is stalled
  assign en          = !hdiv_vld || hsl_o.ready;
  assign pix_i.ready = en;

  rgbhsl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .valid_o (fe_vld),
    .op_o    (fe_op)
  );

  rgbhsl_div #(
    .NW (rgbhsl_pkg::HueNumW),
    .DW (CW),
    .QW (QW),
    .TW (PW + 1)
  ) u_hue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_vld),
    .num_i   (fe_op.hue_num),
    .den_i   (fe_op.delta),
    .tag_i   ({fe_op.grey, fe_op.light}),
    .valid_o (hdiv_vld),
    .quot_o  (hue_quot),
    .tag_o   (htag)
  );

  rgbhsl_div #(
    .NW (rgbhsl_pkg::SatNumW),
    .DW (CW),
    .QW (QW),
    .TW (1)
  ) u_sat_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_vld),
    .num_i   (fe_op.sat_num),
    .den_i   (fe_op.sat_den),
    .tag_i   (fe_op.grey),
    .valid_o (sdiv_vld),
    .quot_o  (sat_quot),
    .tag_o   (sgrey)
  );

  // Drive the result beat, forcing grey pixels to zero hue and saturation
  assign hsl_o.valid              = hdiv_vld;
  assign hsl_o.hue_degrees        = htag[PW] ? '0 : hue_quot;
  assign hsl_o.saturation_percent = sgrey ? '0 : sat_quot[PW-1:0];
  assign hsl_o.lightness_percent  = htag[PW-1:0];

`ifndef SYNTHESIS
  a_div_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdiv_vld == sdiv_vld)
    else $error("hue and saturation dividers out of step");

  a_grey_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdiv_vld |-> (htag[PW] == sgrey))
    else $error("grey flag differs between dividers");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdiv_vld && !sgrey) |-> (sat_quot <= QW'(100)))
    else $error("saturation quotient above 100");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdiv_vld |-> (hsl_o.hue_degrees < 9'd360 && hsl_o.lightness_percent <= 7'd100))
    else $error("hue or lightness out of range");
`endif

endmodule
